@@ design/gpg_pkg.sv @@
// shared constants, types and table generation functions for the gaussian pulse generator
package gpg_pkg;

   localparam int MAX_SAMPLES_DEF = 4096;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int TABLE_BITS_DEF  = 10;

   localparam int LEN_BITS    = 13;
   localparam int OFFSET_BITS = 20;
   localparam int RATE_BITS   = 24;
   localparam int STEP_BITS   = 23;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 24;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_PULSE_LENGTH  = 3'd0,
      CSR_CENTER_OFFSET = 3'd1,
      CSR_ENVELOPE_RATE = 3'd2,
      CSR_PHASE_STEP    = 3'd3,
      CSR_DELTA_MODE    = 3'd4
   } csr_index_type;

   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   function automatic logic [63:0] clamp_q30(input longint sum);
      logic [63:0] res;
      if (sum < 0) res = 64'd0;
      else if (sum > longint'(Q30_ONE)) res = Q30_ONE;
      else res = 64'(sum);
      return res;
   endfunction

   function automatic logic [63:0] cos_q30(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      longint      sum;
      x2   = (x * x) >> 30;
      term = Q30_ONE;
      sum  = longint'(term);
      for (int n = 1; n <= 10; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
         if (n % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      return clamp_q30(sum);
   endfunction

   function automatic logic [63:0] sin_q30(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      longint      sum;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(term);
      for (int n = 1; n <= 10; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      return clamp_q30(sum);
   endfunction

   // exp(-f) for f in [0, 1], q30
   function automatic logic [63:0] expneg_q30(input logic [63:0] f);
      logic [63:0] term;
      longint      sum;
      term = Q30_ONE;
      sum  = longint'(term);
      for (int n = 1; n <= 16; n++) begin
         term = ((term * f) >> 30) / 64'(n);
         if (n % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      return clamp_q30(sum);
   endfunction

   function automatic int to_sample(input logic [63:0] mag, input bit neg, input int sb);
      logic [63:0] v;
      v = (mag + (64'd1 << (30 - sb))) >> (31 - sb);
      if (v > (64'd1 << (sb - 1))) v = 64'd1 << (sb - 1);
      return neg ? -int'(v) : int'(v);
   endfunction

   function automatic int env_entry(input int k, input int tb, input int sb);
      logic [63:0] a;
      logic [63:0] v;
      logic [63:0] e1;
      int          m;
      e1 = expneg_q30(Q30_ONE);
      a  = 64'(k) << (34 - tb);
      v  = expneg_q30(a & (Q30_ONE - 64'd1));
      m  = int'(a >> 30);
      for (int j = 0; j < 16; j++) begin
         if (j < m) v = (v * e1) >> 30;
      end
      return to_sample(v, 1'b0, sb);
   endfunction

   function automatic int cos_entry(input int k, input int tb, input int sb);
      int          q;
      logic [63:0] r;
      logic [63:0] x;
      int          res;
      q = (k >> (tb - 2)) & 3;
      r = 64'(k & ((1 << (tb - 2)) - 1));
      x = (HALF_PI_Q30 * r) >> (tb - 2);
      case (q)
         0:       res = to_sample(cos_q30(x), 1'b0, sb);
         1:       res = to_sample(sin_q30(x), 1'b1, sb);
         2:       res = to_sample(cos_q30(x), 1'b1, sb);
         default: res = to_sample(sin_q30(x), 1'b0, sb);
      endcase
      return res;
   endfunction

endpackage

@@ design/gpg_mul.sv @@
// shared signed multiplier used by the squaring, rate, phase and product steps of the sample sequencer
module gpg_mul
   import gpg_pkg::*;
#(
   parameter int OP_BITS = 26
) (
   input  logic signed [OP_BITS-1:0]   op_a,
   input  logic signed [OP_BITS-1:0]   op_b,
   output logic signed [2*OP_BITS-1:0] product
);

   assign product = op_a * op_b;

endmodule

@@ design/gpg_rom.sv @@
// envelope and cosine lookup tables with registered read
module gpg_rom
   import gpg_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int TABLE_BITS  = TABLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic [TABLE_BITS-1:0]         env_addr,
   input  logic [TABLE_BITS-1:0]         cos_addr,
   output logic signed [SAMPLE_BITS:0]   env_data,
   output logic signed [SAMPLE_BITS:0]   cos_data
);

   localparam int N = 1 << TABLE_BITS;

   logic signed [SAMPLE_BITS:0] env_rom [N];
   logic signed [SAMPLE_BITS:0] cos_rom [N];
   logic signed [SAMPLE_BITS:0] env_data_ff;
   logic signed [SAMPLE_BITS:0] cos_data_ff;

   for (genvar k = 0; k < N; k++) begin : g_rom
      assign env_rom[k] = (SAMPLE_BITS+1)'(env_entry(k, TABLE_BITS, SAMPLE_BITS));
      assign cos_rom[k] = (SAMPLE_BITS+1)'(cos_entry(k, TABLE_BITS, SAMPLE_BITS));
   end

   always_ff @(posedge clock) begin
      env_data_ff <= env_rom[env_addr];
      cos_data_ff <= cos_rom[cos_addr];
   end

   assign env_data = env_data_ff;
   assign cos_data = cos_data_ff;

endmodule

@@ design/gaussian_pulse_generator.sv @@
// gaussian pulse generator: one request gives one sample; pulse samples go through a shared multiplier
// a pulse sample passes through the states SQ, ALO, AHI, PHASE, READ and PROD (five
// multiplies on the one multiplier plus a table read); delta, idle or ended samples are registered directly
// request flow: no new request is taken until the sequencer is back in idle and the response is not stalled
// reset: synchronous active high; clears the state, index, running flag, configuration registers and response valid
module gaussian_pulse_generator
   import gpg_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int TABLE_BITS  = TABLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   output logic                          rsp_last,
   output logic                          rsp_active,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   localparam int IDX_BITS = $clog2(MAX_SAMPLES + 1);
   localparam int LW       = (IDX_BITS > LEN_BITS) ? IDX_BITS : LEN_BITS;
   localparam int MAG_BITS = (IDX_BITS + 8 > OFFSET_BITS) ? IDX_BITS + 8 : OFFSET_BITS;
   localparam int U_BITS   = MAG_BITS + 1;
   localparam int SQ_BITS  = 2 * MAG_BITS - 8;
   localparam int HW       = (SQ_BITS + 1) / 2;
   localparam int A_BITS   = SQ_BITS + RATE_BITS;
   localparam int EW       = SAMPLE_BITS + 1;
   localparam int OPM      = (MAG_BITS > RATE_BITS) ? MAG_BITS : RATE_BITS;
   localparam int OP_BITS  = ((OPM > EW) ? OPM : EW) + 1;
   localparam int PW       = 2 * OP_BITS;
   localparam logic [LW-1:0] MAX_LEN = LW'(MAX_SAMPLES);
   localparam logic signed [SAMPLE_BITS-1:0] FULL_SCALE = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SQ    = 7'b0000010,
      ST_ALO   = 7'b0000100,
      ST_AHI   = 7'b0001000,
      ST_PHASE = 7'b0010000,
      ST_READ  = 7'b0100000,
      ST_PROD  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [LEN_BITS-1:0]    pulse_length_ff;
   logic [OFFSET_BITS-1:0] center_offset_ff;
   logic [RATE_BITS-1:0]   envelope_rate_ff;
   logic [STEP_BITS-1:0]   phase_step_ff;
   logic                   delta_mode_ff;

   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic                running_ff, running_in;
   logic [IDX_BITS-1:0] cur_idx_ff;
   logic                pend_last_ff;

   logic signed [U_BITS-1:0] u_ff;
   logic [SQ_BITS-1:0]       sq_ff;
   logic [HW+RATE_BITS-1:0]  alo_ff;
   logic                     env_zero_ff;
   logic [TABLE_BITS-1:0]    env_addr_ff;
   logic [TABLE_BITS-1:0]    cos_addr_ff;

   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                          rsp_last_ff;
   logic                          rsp_active_ff;

   logic                        req_xfer;
   logic                        rsp_xfer;
   logic [LW-1:0]               len;
   logic                        run_eff;
   logic [IDX_BITS-1:0]         idx_eff;
   logic                        in_pulse;
   logic                        is_last;
   logic signed [U_BITS-1:0]    u_cur;
   logic [MAG_BITS-1:0]         mag_cur;
   logic signed [OP_BITS-1:0]   op_a, op_b;
   logic signed [PW-1:0]        product;
   logic [A_BITS-1:0]           a_sum;
   logic signed [EW-1:0]        env_data, cos_data;
   logic [PW-1:0]               p_mag;
   logic [PW-1:0]               r_mag;
   logic signed [SAMPLE_BITS-1:0] result;

   gpg_mul #(.OP_BITS(OP_BITS)) u_mul (
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   gpg_rom #(.SAMPLE_BITS(SAMPLE_BITS), .TABLE_BITS(TABLE_BITS)) u_rom (
      .clock    (clock),
      .env_addr (env_addr_ff),
      .cos_addr (cos_addr_ff),
      .env_data (env_data),
      .cos_data (cos_data)
   );

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign csr_ready = 1'b1;

   // effective pulse length
   always_comb begin
      if (delta_mode_ff) len = LW'(1);
      else if (LW'(pulse_length_ff) > MAX_LEN) len = MAX_LEN;
      else len = LW'(pulse_length_ff);
   end

   assign run_eff  = req_restart || running_ff;
   assign idx_eff  = req_restart ? '0 : idx_ff;
   assign in_pulse = run_eff && (LW'(idx_eff) < len);
   assign is_last  = (LW'(idx_eff) + LW'(1)) == len;

   assign u_cur   = $signed({1'b0, MAG_BITS'({cur_idx_ff, 8'd0})})
                    - $signed({1'b0, MAG_BITS'(center_offset_ff)});
   assign mag_cur = u_cur[U_BITS-1] ? MAG_BITS'(-u_cur) : MAG_BITS'(u_cur);

   // operand selection for the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff) inside
         ST_SQ: begin
            op_a = $signed({1'b0, (OP_BITS-1)'(mag_cur)});
            op_b = $signed({1'b0, (OP_BITS-1)'(mag_cur)});
         end
         ST_ALO: begin
            op_a = $signed({1'b0, (OP_BITS-1)'(sq_ff[HW-1:0])});
            op_b = $signed({1'b0, (OP_BITS-1)'(envelope_rate_ff)});
         end
         ST_AHI: begin
            op_a = $signed({1'b0, (OP_BITS-1)'(sq_ff[SQ_BITS-1:HW])});
            op_b = $signed({1'b0, (OP_BITS-1)'(envelope_rate_ff)});
         end
         ST_PHASE: begin
            op_a = OP_BITS'(u_ff);
            op_b = $signed({1'b0, (OP_BITS-1)'(phase_step_ff)});
         end
         ST_PROD: begin
            op_a = env_zero_ff ? '0 : OP_BITS'(env_data);
            op_b = OP_BITS'(cos_data);
         end
         ST_IDLE, ST_READ: begin
            op_a = '0;
            op_b = '0;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign a_sum = (A_BITS'(product[SQ_BITS-HW+RATE_BITS-1:0]) << HW) + A_BITS'(alo_ff);

   // round half away from zero, then saturate
   assign p_mag = product[PW-1] ? PW'(-product) : PW'(product);
   assign r_mag = (p_mag + (PW'(1) << (SAMPLE_BITS - 2))) >> (SAMPLE_BITS - 1);
   always_comb begin
      if (product[PW-1]) begin
         if (r_mag >= (PW'(1) << (SAMPLE_BITS - 1)))
            result = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         else
            result = -$signed(SAMPLE_BITS'(r_mag));
      end else begin
         if (r_mag >= (PW'(1) << (SAMPLE_BITS - 1))) result = FULL_SCALE;
         else result = $signed(SAMPLE_BITS'(r_mag));
      end
   end

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      running_in = running_ff;
      if (req_xfer) begin
         idx_in = idx_eff;
         if (in_pulse) begin
            idx_in     = idx_eff + IDX_BITS'(1);
            running_in = !is_last;
            if (!delta_mode_ff) state_in = ST_SQ;
         end else begin
            running_in = 1'b0;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE:  state_in = ST_IDLE;
            ST_SQ:    state_in = ST_ALO;
            ST_ALO:   state_in = ST_AHI;
            ST_AHI:   state_in = ST_PHASE;
            ST_PHASE: state_in = ST_READ;
            ST_READ:  state_in = ST_PROD;
            ST_PROD:  state_in = ST_IDLE;
            default:  state_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         idx_ff           <= '0;
         running_ff       <= 1'b0;
         pulse_length_ff  <= '0;
         center_offset_ff <= '0;
         envelope_rate_ff <= '0;
         phase_step_ff    <= '0;
         delta_mode_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         running_ff <= running_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_PULSE_LENGTH:  pulse_length_ff  <= csr_data[LEN_BITS-1:0];
               CSR_CENTER_OFFSET: center_offset_ff <= csr_data[OFFSET_BITS-1:0];
               CSR_ENVELOPE_RATE: envelope_rate_ff <= csr_data[RATE_BITS-1:0];
               CSR_PHASE_STEP:    phase_step_ff    <= csr_data[STEP_BITS-1:0];
               CSR_DELTA_MODE:    delta_mode_ff    <= csr_data[0];
               default: ;
            endcase
         end
         if (req_xfer && (delta_mode_ff || !in_pulse)) rsp_valid_ff <= 1'b1;
         else if (state_ff == ST_PROD) rsp_valid_ff <= 1'b1;
         else if (rsp_xfer) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cur_idx_ff   <= idx_eff;
         pend_last_ff <= is_last;
         if (!in_pulse) begin
            rsp_sample_ff <= '0;
            rsp_last_ff   <= 1'b0;
            rsp_active_ff <= 1'b0;
         end else if (delta_mode_ff) begin
            rsp_sample_ff <= FULL_SCALE;
            rsp_last_ff   <= 1'b1;
            rsp_active_ff <= 1'b1;
         end
      end
      if (state_ff == ST_SQ) begin
         u_ff  <= u_cur;
         sq_ff <= product[SQ_BITS+7:8];
      end
      if (state_ff == ST_ALO) alo_ff <= product[HW+RATE_BITS-1:0];
      if (state_ff == ST_AHI) begin
         env_zero_ff <= |a_sum[A_BITS-1:36];
         env_addr_ff <= a_sum[35 -: TABLE_BITS];
      end
      if (state_ff == ST_PHASE) cos_addr_ff <= product[31 -: TABLE_BITS];
      if (state_ff == ST_PROD) begin
         rsp_sample_ff <= result;
         rsp_last_ff   <= pend_last_ff;
         rsp_active_ff <= 1'b1;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_active = rsp_active_ff;

endmodule

@@ tb/tb_top.sv @@
// testbench for the gaussian pulse generator: directed and random transfers checked against a bit-exact predictor
`timescale 1ns / 100ps

module tb_top
   import gpg_pkg::*;
();

   typedef struct packed {
      logic signed [15:0] sample;
      logic               last;
      logic               active;
   } pulse_out_type;

   class pulse_scoreboard;
      int              env_tab[1024];
      int              cos_tab[1024];
      bit [12:0]       pulse_len;
      bit [19:0]       offset;
      bit [23:0]       rate;
      bit [22:0]       step;
      bit              delta;
      int unsigned     idx;
      bit              running;
      pulse_out_type   expected_q[$];
      int              mismatches;

      function new();
         bit [63:0] e1, a, v, x;
         int q, r;
         e1 = exp_neg(64'd1 << 30);
         for (int k = 0; k < 1024; k++) begin
            a = 64'(k) << 24;
            v = exp_neg(a & ((64'd1 << 30) - 1));
            for (bit [63:0] m = a >> 30; m > 0; m--) v = (v * e1) >> 30;
            env_tab[k] = quantize(v, 1'b0);
            q = k / 256;
            r = k % 256;
            x = (64'd1686629713 * 64'(r)) >> 8;
            case (q)
               0: cos_tab[k] = quantize(series(x, 1'b0), 1'b0);
               1: cos_tab[k] = quantize(series(x, 1'b1), 1'b1);
               2: cos_tab[k] = quantize(series(x, 1'b0), 1'b1);
               default: cos_tab[k] = quantize(series(x, 1'b1), 1'b0);
            endcase
         end
         idx = 0;
         running = 0;
         mismatches = 0;
      endfunction

      // taylor series of cos (odd_fn=0) or sin (odd_fn=1), q30
      function bit [63:0] series(bit [63:0] x, bit odd_fn);
         bit [63:0] x2, term;
         longint sum;
         x2 = (x * x) >> 30;
         term = odd_fn ? x : (64'd1 << 30);
         sum = longint'(term);
         for (int n = 1; n <= 10; n++) begin
            if (odd_fn) term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            else term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
         end
         return clip(sum);
      endfunction

      function bit [63:0] exp_neg(bit [63:0] f);
         bit [63:0] term;
         longint sum;
         term = 64'd1 << 30;
         sum = longint'(term);
         for (int n = 1; n <= 16; n++) begin
            term = ((term * f) >> 30) / 64'(n);
            if (n % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
         end
         return clip(sum);
      endfunction

      function bit [63:0] clip(longint s);
         if (s < 0) return 0;
         if (s > longint'(64'd1 << 30)) return 64'd1 << 30;
         return 64'(s);
      endfunction

      function int quantize(bit [63:0] mag, bit neg);
         bit [63:0] v;
         v = (mag + (64'd1 << 14)) >> 15;
         if (v > 64'd32768) v = 64'd32768;
         return neg ? -int'(v) : int'(v);
      endfunction

      function int pulse_value(int unsigned i);
         longint u, env, c, p, r;
         bit [63:0] mag, a, pm;
         bit [31:0] ph;
         u = longint'(i) * 256 - longint'(offset);
         mag = (u < 0) ? 64'(-u) : 64'(u);
         a = ((mag * mag) >> 8) * 64'(rate);
         env = (a < (64'd16 << 32)) ? env_tab[(a >> 26) & 1023] : 0;
         ph = 32'(64'(step) * 64'(u));
         c = cos_tab[ph >> 22];
         p = env * c;
         pm = (p < 0) ? 64'(-p) : 64'(p);
         r = longint'((pm + 64'd16384) >> 15);
         if (p < 0) r = -r;
         if (r > 32767) r = 32767;
         if (r < -32768) r = -32768;
         return int'(r);
      endfunction

      function void write_reg(csr_index_type ix, bit [23:0] d);
         case (ix)
            CSR_PULSE_LENGTH:  pulse_len = d[12:0];
            CSR_CENTER_OFFSET: offset = d[19:0];
            CSR_ENVELOPE_RATE: rate = d;
            CSR_PHASE_STEP:    step = d[22:0];
            CSR_DELTA_MODE:    delta = d[0];
            default: ;
         endcase
      endfunction

      function void note_request(bit restart);
         int unsigned len;
         pulse_out_type e;
         e = '0;
         if (restart) begin
            idx = 0;
            running = 1;
         end
         len = delta ? 1 : (pulse_len > 4096 ? 4096 : pulse_len);
         if (running && idx < len) begin
            e.sample = delta ? 16'sd32767 : 16'(pulse_value(idx));
            e.active = 1;
            e.last = (idx + 1 == len);
            idx++;
            if (e.last) running = 0;
         end else begin
            running = 0;
         end
         expected_q.push_back(e);
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $time, what);
         mismatches++;
      endtask

      task check_sample(logic signed [15:0] s, logic l, logic act);
         pulse_out_type e;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected response");
            return;
         end
         e = expected_q.pop_front();
         if (s !== e.sample) report_mismatch($sformatf("sample %0d exp %0d", s, e.sample));
         if (l !== e.last) report_mismatch($sformatf("last %b exp %b", l, e.last));
         if (act !== e.active) report_mismatch($sformatf("active %b exp %b", act, e.active));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic req_restart = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [15:0] rsp_sample;
   logic rsp_last, rsp_active;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   pulse_scoreboard sb = new();
   int  cycles = 0;
   bit  holdoff_req = 0;
   int  stall_mode = 0;

   gaussian_pulse_generator dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 600000) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) sb.check_sample(rsp_sample, rsp_last, rsp_active);

   // receiver stall pattern, with one long hold-off on request
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (holdoff_req) begin
            holdoff_req = 0;
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_stall = 1;
         end else begin
            case (stall_mode)
               0: rsp_stall = 0;
               1: rsp_stall = ($urandom_range(0, 3) == 0);
               default: rsp_stall = ($urandom_range(0, 1) == 0);
            endcase
            if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
         end
      end
   end

   task automatic write_csr(csr_index_type ix, bit [23:0] d);
      @(negedge clock);
      csr_valid = 1;
      csr_index = ix;
      csr_data = d;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(ix, d);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic send_request(bit restart);
      @(negedge clock);
      req_valid = 1;
      req_restart = restart;
      do @(posedge clock); while (req_stall);
      sb.note_request(restart);
   endtask

   task automatic pause_sender(int n);
      @(negedge clock);
      req_valid = 0;
      req_restart = $urandom_range(0, 1);
      repeat (n) @(negedge clock);
   endtask

   task automatic wait_drained();
      pause_sender(0);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_pulse(bit [12:0] len, bit [19:0] off, bit [23:0] rt, bit [22:0] st,
                            bit dm);
      write_csr(CSR_PULSE_LENGTH, 24'(len));
      write_csr(CSR_CENTER_OFFSET, 24'(off));
      write_csr(CSR_ENVELOPE_RATE, rt);
      write_csr(CSR_PHASE_STEP, 24'(st));
      write_csr(CSR_DELTA_MODE, 24'(dm));
   endtask

   task automatic random_traffic(int n, int restart_odds);
      int sent, burst;
      sent = 0;
      while (sent < n) begin
         burst = $urandom_range(1, 30);
         for (int b = 0; b < burst && sent < n; b++) begin
            send_request($urandom_range(0, restart_odds) == 0);
            sent++;
         end
         if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(0, 12));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: idle advance, full short pulse, restart mid-pulse, advance past end
      set_pulse(13'd12, 20'd1536, 24'd300000, 23'd1500000, 1'b0);
      send_request(0);
      send_request(1);
      repeat (13) send_request(0);
      send_request(1);
      repeat (4) send_request(0);
      send_request(1);
      wait_drained();
      // delta mode
      set_pulse(13'd12, 20'd0, 24'd0, 23'd0, 1'b1);
      send_request(1); send_request(0); send_request(1); send_request(1);
      wait_drained();
      // zero length
      set_pulse(13'd0, 20'd1048575, 24'd16777215, 23'd8388607, 1'b0);
      send_request(1); send_request(0);
      wait_drained();
      // long pulse, saturated length, with a long receiver hold-off
      set_pulse(13'd8191, 20'd1048575, 24'd16777215, 23'd8388607, 1'b0);
      holdoff_req = 1;
      random_traffic(150, 200);
      wait_drained();
      set_pulse(13'd4096, 20'd0, 24'd0, 23'd0, 1'b0);
      random_traffic(100, 300);
      wait_drained();
      set_pulse(13'd20, 20'd2560, 24'd2000000, 23'd3000000, 1'b0);
      random_traffic(150, 15);
      wait_drained();
      set_pulse(13'd1, 20'd256, 24'd16777215, 23'd8388607, 1'b0);
      random_traffic(60, 2);
      wait_drained();
      set_pulse(13'd40, 20'd5120, 24'd100000, 23'd700000, 1'b1);
      random_traffic(60, 3);
      wait_drained();
      for (int p = 0; p < 8; p++) begin
         set_pulse(13'($urandom_range(0, 64)), 20'($urandom_range(0, 20000)),
                   24'($urandom), 23'($urandom), ($urandom_range(0, 5) == 0));
         random_traffic(100, $urandom_range(3, 40));
         wait_drained();
      end
      if (sb.mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

@@ gaussian_pulse_generator.f @@
design/gpg_pkg.sv
design/gpg_mul.sv
design/gpg_rom.sv
design/gaussian_pulse_generator.sv
tb/tb_top.sv
